// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the request log statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, checked on the rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== rtl/core/rlst_pkg.sv =====
// ----------------------------------------------------------------------------
// rlst_pkg
// Widths, record kinds, status limits and register indexes of the request
// log statistics block.
// ----------------------------------------------------------------------------
package rlst_pkg;

   localparam int HIT_W = 40;
   localparam int SUM_W = 64;
   localparam int TIME_W = 32;
   localparam int ENT_W = HIT_W + SUM_W;

   // record kinds
   localparam logic [3:0] KIND_TOTAL    = 4'd0;
   localparam logic [3:0] KIND_OK       = 4'd1;
   localparam logic [3:0] KIND_FAILED   = 4'd2;
   localparam logic [3:0] KIND_AVERAGE  = 4'd3;
   localparam logic [3:0] KIND_MIN      = 4'd4;
   localparam logic [3:0] KIND_MAX      = 4'd5;
   localparam logic [3:0] KIND_BYTES    = 4'd6;
   localparam logic [3:0] KIND_CLASS2   = 4'd7;
   localparam logic [3:0] KIND_CLASS3   = 4'd8;
   localparam logic [3:0] KIND_CLASS4   = 4'd9;
   localparam logic [3:0] KIND_CLASS5   = 4'd10;
   localparam logic [3:0] KIND_BUSIEST  = 4'd11;
   localparam logic [3:0] KIND_SERVER   = 4'd12;
   localparam logic [3:0] KIND_ENDPOINT = 4'd13;

   // status class bounds
   localparam logic [9:0] STATUS_200 = 10'd200;
   localparam logic [9:0] STATUS_300 = 10'd300;
   localparam logic [9:0] STATUS_400 = 10'd400;
   localparam logic [9:0] STATUS_500 = 10'd500;
   localparam logic [9:0] STATUS_600 = 10'd600;

   // timestamp / 60 as (timestamp * RECIP_60) >> SHIFT_60, exact for 32 bits
   localparam logic [31:0] RECIP_60 = 32'h8888_8889;
   localparam int SHIFT_60 = 37;

   // register indexes
   localparam logic CSR_TOP_COUNT    = 1'b0;
   localparam logic CSR_SERVER_LIMIT = 1'b1;

   localparam logic [4:0] TOP_COUNT_RESET    = 5'd10;
   localparam logic [6:0] SERVER_LIMIT_RESET = 7'd64;

endpackage

// ===== rtl/core/rlst_ram.sv =====
// ----------------------------------------------------------------------------
// rlst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rlst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rlst_div.sv =====
// ----------------------------------------------------------------------------
// rlst_div
// Restoring divider, one quotient bit per cycle: 64-bit sum by 40-bit count.
// ----------------------------------------------------------------------------
module rlst_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rlst_pkg::SUM_W-1:0] dividend,
   input  logic [rlst_pkg::HIT_W-1:0] divisor,
   output logic                      done,
   output logic [rlst_pkg::SUM_W-1:0] quotient
);

   import rlst_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [HIT_W:0]   rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [HIT_W-1:0] dvs_ff, dvs_in;
   logic [HIT_W:0]   rem_sh;
   logic             ge;

   // one shift-subtract step per cycle
   always_comb begin
      rem_sh = {rem_ff[HIT_W-1:0], quo_ff[SUM_W-1]};
      ge = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         quo_in = {quo_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/request_log_statistics_topk.sv =====
// ----------------------------------------------------------------------------
// request_log_statistics_topk
// Tallies web request records and emits a statistics report with top lists.
// ----------------------------------------------------------------------------
// Usage: after reset the block clears its tables with busy high. A tally
// request (operation 0) does a read-modify-write of the server and endpoint
// RAMs, then of the interval RAM, with the interval index formed by a
// reciprocal multiply. A report request (operation 1) walks the tables
// through their single read ports and shares one bit-serial divider between
// the overall average and the per-server averages: one scan for the busiest
// interval, one per listed server and per listed endpoint, plus one scan for
// the first missing entry of a short list. Report records leave one per
// rsp_valid strobe with no back pressure; the receiver must take every
// strobe. busy drops in the cycle in which the record marked rsp_last is
// presented.
`include "assert_macros.svh"

module request_log_statistics_topk #(
   parameter int SERVERS   = 64,
   parameter int ENDPOINTS = 256,
   parameter int INTERVALS = 1024,
   parameter int MAX_TOP   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_operation,
   input  logic [31:0]                req_timestamp,
   input  logic [7:0]                 req_server_id,
   input  logic [15:0]                req_endpoint_id,
   input  logic [9:0]                 req_status_code,
   input  logic [31:0]                req_response_time,
   input  logic [31:0]                req_byte_count,
   output logic                       rsp_valid,
   output logic [3:0]                 rsp_record_kind,
   output logic [15:0]                rsp_entry_id,
   output logic [rlst_pkg::HIT_W-1:0] rsp_hit_count,
   output logic [rlst_pkg::SUM_W-1:0] rsp_amount,
   output logic                       rsp_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   import rlst_pkg::*;

   localparam int SAW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
   localparam int EAW = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
   localparam int IAW = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
   localparam int MAXD_SE = (SERVERS > ENDPOINTS) ? SERVERS : ENDPOINTS;
   localparam int MAXD = (MAXD_SE > INTERVALS) ? MAXD_SE : INTERVALS;
   localparam int CW = $clog2(MAXD + 1);
   localparam int IV_W = 64 - SHIFT_60;

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b000_0000_0001,
      S_IDLE   = 11'b000_0000_0010,
      S_REC_RD = 11'b000_0000_0100,
      S_REC_IV = 11'b000_0000_1000,
      S_REC_WR = 11'b000_0001_0000,
      S_AVG    = 11'b000_0010_0000,
      S_FIXED  = 11'b000_0100_0000,
      S_SCAN   = 11'b000_1000_0000,
      S_DIV    = 11'b001_0000_0000,
      S_NEXT   = 11'b010_0000_0000,
      S_FLUSH  = 11'b100_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      TBL_IV  = 2'd0,
      TBL_SRV = 2'd1,
      TBL_EP  = 2'd2
   } tbl_type;

   state_type state_ff, state_in;
   tbl_type   tbl_ff, tbl_in;

   // latched request
   logic [31:0] ts_ff;
   logic [7:0]  srv_ff;
   logic [15:0] ep_ff;
   logic [9:0]  st_ff;
   logic [31:0] rt_ff;
   logic [31:0] by_ff;
   logic [IV_W-1:0] iv_ff;
   logic [63:0] iv_prod;

   // scalar statistics
   logic [HIT_W-1:0]  req_total_ff, req_total_in;
   logic [HIT_W-1:0]  ok_total_ff, ok_total_in;
   logic [HIT_W-1:0]  fail_total_ff, fail_total_in;
   logic [HIT_W-1:0]  class_ff [4];
   logic [HIT_W-1:0]  class_in [4];
   logic [SUM_W-1:0]  rsum_ff, rsum_in;
   logic [TIME_W-1:0] rmin_ff, rmin_in;
   logic [TIME_W-1:0] rmax_ff, rmax_in;
   logic [SUM_W-1:0]  bytes_ff, bytes_in;

   // configuration
   logic [4:0] top_count_ff, top_count_in;
   logic [6:0] server_limit_ff, server_limit_in;
   logic [4:0] lim;

   // sequencer
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic [4:0]       k_ff, k_in;
   logic             have_prev_ff, have_prev_in;
   logic [HIT_W-1:0] prev_c_ff, prev_c_in;
   logic [CW-1:0]    prev_i_ff, prev_i_in;
   logic             found_ff, found_in;
   logic [HIT_W-1:0] best_c_ff, best_c_in;
   logic [CW-1:0]    best_i_ff, best_i_in;
   logic [SUM_W-1:0] best_amt_ff, best_amt_in;
   logic [SUM_W-1:0] avg_ff, avg_in;
   logic             avg_mode_ff, avg_mode_in;
   logic [3:0]       fix_ff, fix_in;

   // pending and output records
   logic             pend_vld_ff, pend_vld_in;
   logic [3:0]       pend_kind_ff, pend_kind_in;
   logic [15:0]      pend_id_ff, pend_id_in;
   logic [HIT_W-1:0] pend_hits_ff, pend_hits_in;
   logic [SUM_W-1:0] pend_amt_ff, pend_amt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [3:0]       rsp_kind_ff, rsp_kind_in;
   logic [15:0]      rsp_id_ff, rsp_id_in;
   logic [HIT_W-1:0] rsp_hits_ff, rsp_hits_in;
   logic [SUM_W-1:0] rsp_amt_ff, rsp_amt_in;

   // produced record
   logic             prod_vld;
   logic [3:0]       prod_kind;
   logic [15:0]      prod_id;
   logic [HIT_W-1:0] prod_hits;
   logic [SUM_W-1:0] prod_amt;

   // table RAMs
   logic             srv_we, ep_we, iv_we;
   logic [SAW-1:0]   srv_waddr, srv_raddr;
   logic [EAW-1:0]   ep_waddr, ep_raddr;
   logic [IAW-1:0]   iv_waddr, iv_raddr;
   logic [ENT_W-1:0] srv_wdata, srv_rdata, ep_wdata, ep_rdata;
   logic [HIT_W-1:0] iv_wdata, iv_rdata;

   // divider
   logic             div_start, div_done;
   logic [SUM_W-1:0] div_dividend, div_quotient;
   logic [HIT_W-1:0] div_divisor;

   // scan compare
   logic [CW-1:0]    scan_size;
   logic [HIT_W-1:0] scan_c;
   logic [SUM_W-1:0] scan_amt;
   logic             after_prev, take;

   logic accept, cfg_wr, any_req;
   logic srv_ok, ep_ok, iv_ok;

   assign accept = start && (state_ff == S_IDLE);
   assign cfg_wr = psel && penable && pwrite;
   assign any_req = req_total_ff != '0;
   assign lim = (top_count_ff > 5'(MAX_TOP)) ? 5'(MAX_TOP) : top_count_ff;

   // interval index by reciprocal multiply
   assign iv_prod = ts_ff * RECIP_60;

   assign srv_ok = ({1'b0, srv_ff} < {2'b0, server_limit_ff}) && (9'(srv_ff) < 9'(SERVERS));
   assign ep_ok = 17'(ep_ff) < 17'(ENDPOINTS);
   assign iv_ok = 32'(iv_ff) < 32'(INTERVALS);

   rlst_ram #(.WIDTH(ENT_W), .DEPTH(SERVERS)) u_srv_ram (
      .clock(clock), .wr_en(srv_we), .wr_addr(srv_waddr), .wr_data(srv_wdata),
      .rd_addr(srv_raddr), .rd_data(srv_rdata)
   );

   rlst_ram #(.WIDTH(ENT_W), .DEPTH(ENDPOINTS)) u_ep_ram (
      .clock(clock), .wr_en(ep_we), .wr_addr(ep_waddr), .wr_data(ep_wdata),
      .rd_addr(ep_raddr), .rd_data(ep_rdata)
   );

   rlst_ram #(.WIDTH(HIT_W), .DEPTH(INTERVALS)) u_iv_ram (
      .clock(clock), .wr_en(iv_we), .wr_addr(iv_waddr), .wr_data(iv_wdata),
      .rd_addr(iv_raddr), .rd_data(iv_rdata)
   );

   rlst_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_quotient)
   );

   // RAM ports: clear sweep, request read-modify-write, report scan
   always_comb begin
      srv_raddr = (state_ff == S_SCAN) ? cnt_ff[SAW-1:0] : srv_ff[SAW-1:0];
      ep_raddr = (state_ff == S_SCAN) ? cnt_ff[EAW-1:0] : ep_ff[EAW-1:0];
      iv_raddr = (state_ff == S_SCAN) ? cnt_ff[IAW-1:0] : iv_ff[IAW-1:0];
      if (state_ff == S_CLEAR) begin
         srv_we = cnt_ff < CW'(SERVERS);
         ep_we = cnt_ff < CW'(ENDPOINTS);
         iv_we = cnt_ff < CW'(INTERVALS);
         srv_waddr = cnt_ff[SAW-1:0];
         ep_waddr = cnt_ff[EAW-1:0];
         iv_waddr = cnt_ff[IAW-1:0];
         srv_wdata = '0;
         ep_wdata = '0;
         iv_wdata = '0;
      end else begin
         srv_we = (state_ff == S_REC_IV) && srv_ok;
         ep_we = (state_ff == S_REC_IV) && ep_ok;
         iv_we = (state_ff == S_REC_WR) && iv_ok;
         srv_waddr = srv_ff[SAW-1:0];
         ep_waddr = ep_ff[EAW-1:0];
         iv_waddr = iv_ff[IAW-1:0];
         srv_wdata = {srv_rdata[ENT_W-1:SUM_W] + 1'b1,
                      srv_rdata[SUM_W-1:0] + SUM_W'(rt_ff)};
         ep_wdata = {ep_rdata[ENT_W-1:SUM_W] + 1'b1,
                     ep_rdata[SUM_W-1:0] + SUM_W'(by_ff)};
         iv_wdata = iv_rdata + 1'b1;
      end
   end

   // scan compare against the previous pick and the best so far
   always_comb begin
      case (tbl_ff)
         TBL_IV: begin
            scan_size = CW'(INTERVALS);
            scan_c = iv_rdata;
            scan_amt = '0;
         end
         TBL_SRV: begin
            scan_size = CW'(SERVERS);
            scan_c = srv_rdata[ENT_W-1:SUM_W];
            scan_amt = srv_rdata[SUM_W-1:0];
         end
         TBL_EP: begin
            scan_size = CW'(ENDPOINTS);
            scan_c = ep_rdata[ENT_W-1:SUM_W];
            scan_amt = ep_rdata[SUM_W-1:0];
         end
         default: begin
            scan_size = '0;
            scan_c = '0;
            scan_amt = '0;
         end
      endcase
      after_prev = !have_prev_ff || (prev_c_ff > scan_c) ||
                   ((prev_c_ff == scan_c) && (prev_i_ff < rd_idx_ff));
      take = rd_vld_ff && (scan_c != '0) && after_prev &&
             (!found_ff || (scan_c > best_c_ff));
   end

   // divider operands: overall average or a server average
   assign div_dividend = (state_ff == S_AVG) ? rsum_ff : best_amt_ff;
   assign div_divisor = (state_ff == S_AVG) ? req_total_ff : best_c_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      tbl_in = tbl_ff;
      cnt_in = cnt_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      k_in = k_ff;
      have_prev_in = have_prev_ff;
      prev_c_in = prev_c_ff;
      prev_i_in = prev_i_ff;
      found_in = found_ff;
      best_c_in = best_c_ff;
      best_i_in = best_i_ff;
      best_amt_in = best_amt_ff;
      avg_in = avg_ff;
      avg_mode_in = avg_mode_ff;
      fix_in = fix_ff;
      div_start = 1'b0;
      prod_vld = 1'b0;
      prod_kind = KIND_TOTAL;
      prod_id = '0;
      prod_hits = '0;
      prod_amt = '0;
      req_total_in = req_total_ff;
      ok_total_in = ok_total_ff;
      fail_total_in = fail_total_ff;
      class_in = class_ff;
      rsum_in = rsum_ff;
      rmin_in = rmin_ff;
      rmax_in = rmax_ff;
      bytes_in = bytes_ff;

      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAXD - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = req_operation ? S_AVG : S_REC_RD;
            end
         end
         S_REC_RD: begin
            state_in = S_REC_IV;
         end
         S_REC_IV: begin
            state_in = S_REC_WR;
         end
         S_REC_WR: begin
            // fold the request into the scalar totals
            req_total_in = req_total_ff + 1'b1;
            if (st_ff < STATUS_400) begin
               ok_total_in = ok_total_ff + 1'b1;
            end else begin
               fail_total_in = fail_total_ff + 1'b1;
            end
            if ((st_ff >= STATUS_200) && (st_ff < STATUS_300)) begin
               class_in[0] = class_ff[0] + 1'b1;
            end else if ((st_ff >= STATUS_300) && (st_ff < STATUS_400)) begin
               class_in[1] = class_ff[1] + 1'b1;
            end else if ((st_ff >= STATUS_400) && (st_ff < STATUS_500)) begin
               class_in[2] = class_ff[2] + 1'b1;
            end else if ((st_ff >= STATUS_500) && (st_ff < STATUS_600)) begin
               class_in[3] = class_ff[3] + 1'b1;
            end
            rsum_in = rsum_ff + SUM_W'(rt_ff);
            if (rt_ff < rmin_ff) begin
               rmin_in = rt_ff;
            end
            if (rt_ff > rmax_ff) begin
               rmax_in = rt_ff;
            end
            bytes_in = bytes_ff + SUM_W'(by_ff);
            state_in = S_IDLE;
         end
         S_AVG: begin
            avg_mode_in = 1'b1;
            fix_in = KIND_TOTAL;
            if (any_req) begin
               div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               avg_in = '0;
               state_in = S_FIXED;
            end
         end
         S_FIXED: begin
            // emit the scalar records in kind order
            prod_vld = 1'b1;
            prod_kind = fix_ff;
            case (fix_ff)
               KIND_TOTAL:   prod_hits = req_total_ff;
               KIND_OK:      prod_hits = ok_total_ff;
               KIND_FAILED:  prod_hits = fail_total_ff;
               KIND_AVERAGE: prod_amt = avg_ff;
               KIND_MIN:     prod_amt = any_req ? SUM_W'(rmin_ff) : '0;
               KIND_MAX:     prod_amt = any_req ? SUM_W'(rmax_ff) : '0;
               KIND_BYTES:   prod_amt = bytes_ff;
               KIND_CLASS2:  prod_hits = class_ff[0];
               KIND_CLASS3:  prod_hits = class_ff[1];
               KIND_CLASS4:  prod_hits = class_ff[2];
               KIND_CLASS5:  prod_hits = class_ff[3];
               default:      prod_hits = '0;
            endcase
            fix_in = fix_ff + 1'b1;
            if (fix_ff == KIND_CLASS5) begin
               tbl_in = TBL_IV;
               have_prev_in = 1'b0;
               cnt_in = '0;
               found_in = 1'b0;
               best_c_in = '0;
               best_i_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one read a cycle, judge the entry read the cycle before
            if (cnt_ff < scan_size) begin
               cnt_in = cnt_ff + 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff;
            end
            if (take) begin
               found_in = 1'b1;
               best_c_in = scan_c;
               best_i_in = rd_idx_ff;
               best_amt_in = scan_amt;
            end
            if ((cnt_ff == scan_size) && !rd_vld_ff) begin
               case (tbl_ff)
                  TBL_IV: begin
                     prod_vld = 1'b1;
                     prod_kind = KIND_BUSIEST;
                     prod_id = 16'(best_i_ff);
                     prod_hits = best_c_ff;
                     tbl_in = TBL_SRV;
                     k_in = '0;
                     have_prev_in = 1'b0;
                     state_in = S_NEXT;
                  end
                  TBL_SRV: begin
                     if (found_ff) begin
                        avg_mode_in = 1'b0;
                        div_start = 1'b1;
                        state_in = S_DIV;
                     end else begin
                        tbl_in = TBL_EP;
                        k_in = '0;
                        have_prev_in = 1'b0;
                        state_in = S_NEXT;
                     end
                  end
                  default: begin
                     if (found_ff) begin
                        prod_vld = 1'b1;
                        prod_kind = KIND_ENDPOINT;
                        prod_id = 16'(best_i_ff);
                        prod_hits = best_c_ff;
                        prod_amt = best_amt_ff;
                        have_prev_in = 1'b1;
                        prev_c_in = best_c_ff;
                        prev_i_in = best_i_ff;
                        k_in = k_ff + 1'b1;
                        state_in = S_NEXT;
                     end else begin
                        state_in = S_FLUSH;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (avg_mode_ff) begin
                  avg_in = div_quotient;
                  state_in = S_FIXED;
               end else begin
                  prod_vld = 1'b1;
                  prod_kind = KIND_SERVER;
                  prod_id = 16'(best_i_ff);
                  prod_hits = best_c_ff;
                  prod_amt = div_quotient;
                  have_prev_in = 1'b1;
                  prev_c_in = best_c_ff;
                  prev_i_in = best_i_ff;
                  k_in = k_ff + 1'b1;
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            // next pick of the current list, or move on
            if (k_ff < lim) begin
               cnt_in = '0;
               found_in = 1'b0;
               best_c_in = '0;
               best_i_in = '0;
               state_in = S_SCAN;
            end else if (tbl_ff == TBL_SRV) begin
               tbl_in = TBL_EP;
               k_in = '0;
               have_prev_in = 1'b0;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold one record back so the final one can carry the last flag
   always_comb begin
      pend_vld_in = pend_vld_ff;
      pend_kind_in = pend_kind_ff;
      pend_id_in = pend_id_ff;
      pend_hits_in = pend_hits_ff;
      pend_amt_in = pend_amt_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in = 1'b0;
      rsp_kind_in = pend_kind_ff;
      rsp_id_in = pend_id_ff;
      rsp_hits_in = pend_hits_ff;
      rsp_amt_in = pend_amt_ff;
      if (state_ff == S_FLUSH) begin
         rsp_valid_in = pend_vld_ff;
         rsp_last_in = 1'b1;
         pend_vld_in = 1'b0;
      end else if (prod_vld) begin
         rsp_valid_in = pend_vld_ff;
         pend_vld_in = 1'b1;
         pend_kind_in = prod_kind;
         pend_id_in = prod_id;
         pend_hits_in = prod_hits;
         pend_amt_in = prod_amt;
      end
   end

   // configuration writes
   always_comb begin
      top_count_in = top_count_ff;
      server_limit_in = server_limit_ff;
      if (cfg_wr) begin
         case (paddr[2])
            CSR_TOP_COUNT:    top_count_in = pwdata[4:0];
            CSR_SERVER_LIMIT: server_limit_in = pwdata[6:0];
            default:          top_count_in = top_count_ff;
         endcase
      end
   end

   assign prdata = (paddr[2] == CSR_SERVER_LIMIT) ? {25'b0, server_limit_ff} :
                                                    {27'b0, top_count_ff};
   assign pready = 1'b1;

   // control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         tbl_ff <= TBL_IV;
         cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         k_ff <= '0;
         have_prev_ff <= 1'b0;
         found_ff <= 1'b0;
         avg_mode_ff <= 1'b0;
         fix_ff <= KIND_TOTAL;
         pend_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         req_total_ff <= '0;
         ok_total_ff <= '0;
         fail_total_ff <= '0;
         class_ff <= '{default: '0};
         rsum_ff <= '0;
         rmin_ff <= '1;
         rmax_ff <= '0;
         bytes_ff <= '0;
         top_count_ff <= TOP_COUNT_RESET;
         server_limit_ff <= SERVER_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         tbl_ff <= tbl_in;
         cnt_ff <= cnt_in;
         rd_vld_ff <= rd_vld_in;
         k_ff <= k_in;
         have_prev_ff <= have_prev_in;
         found_ff <= found_in;
         avg_mode_ff <= avg_mode_in;
         fix_ff <= fix_in;
         pend_vld_ff <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         req_total_ff <= req_total_in;
         ok_total_ff <= ok_total_in;
         fail_total_ff <= fail_total_in;
         class_ff <= class_in;
         rsum_ff <= rsum_in;
         rmin_ff <= rmin_in;
         rmax_ff <= rmax_in;
         bytes_ff <= bytes_in;
         top_count_ff <= top_count_in;
         server_limit_ff <= server_limit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      prev_c_ff <= prev_c_in;
      prev_i_ff <= prev_i_in;
      best_c_ff <= best_c_in;
      best_i_ff <= best_i_in;
      best_amt_ff <= best_amt_in;
      avg_ff <= avg_in;
      pend_kind_ff <= pend_kind_in;
      pend_id_ff <= pend_id_in;
      pend_hits_ff <= pend_hits_in;
      pend_amt_ff <= pend_amt_in;
      rsp_last_ff <= rsp_last_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff <= rsp_id_in;
      rsp_hits_ff <= rsp_hits_in;
      rsp_amt_ff <= rsp_amt_in;
      if (state_ff == S_REC_RD) begin
         iv_ff <= iv_prod[63:SHIFT_60];
      end
      if (accept) begin
         ts_ff <= req_timestamp;
         srv_ff <= req_server_id;
         ep_ff <= req_endpoint_id;
         st_ff <= req_status_code;
         rt_ff <= req_response_time;
         by_ff <= req_byte_count;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_record_kind = rsp_kind_ff;
   assign rsp_entry_id = rsp_id_ff;
   assign rsp_hit_count = rsp_hits_ff;
   assign rsp_amount = rsp_amt_ff;
   assign rsp_last = rsp_last_ff;

   // checks
   `ASSERT_NEXT(a_last_ends_report, clock, reset, rsp_valid && rsp_last, !rsp_valid)
   `ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLY(a_div_done_in_wait, clock, reset, div_done, state_ff == S_DIV)
   `ASSERT_IMPLY(a_quiet_while_clear, clock, reset, state_ff == S_CLEAR, !rsp_valid)

endmodule

// ===== tb/request_log_statistics_topk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_log_statistics_topk_checker
// Watches the request, report and register ports of the request log
// statistics block, keeps its own copy of the tallies and compares every
// report record against the predicted one, in order.
// ----------------------------------------------------------------------------
module request_log_statistics_topk_checker #(
   parameter int SERVERS   = 64,
   parameter int ENDPOINTS = 256,
   parameter int INTERVALS = 1024,
   parameter int MAX_TOP   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       req_operation,
   input  logic [31:0]                req_timestamp,
   input  logic [7:0]                 req_server_id,
   input  logic [15:0]                req_endpoint_id,
   input  logic [9:0]                 req_status_code,
   input  logic [31:0]                req_response_time,
   input  logic [31:0]                req_byte_count,
   input  logic                       rsp_valid,
   input  logic [3:0]                 rsp_record_kind,
   input  logic [15:0]                rsp_entry_id,
   input  logic [rlst_pkg::HIT_W-1:0] rsp_hit_count,
   input  logic [rlst_pkg::SUM_W-1:0] rsp_amount,
   input  logic                       rsp_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   input  logic                       pready,
   output int                         failures,
   output int                         outstanding
);

   import rlst_pkg::*;

   typedef struct packed {
      logic [3:0]       kind;
      logic [15:0]      id;
      logic [HIT_W-1:0] hits;
      logic [SUM_W-1:0] amount;
      logic             last;
   } stat_record_type;

   stat_record_type report_queue[$];

   // register copies
   logic [4:0] top_count;
   logic [6:0] server_limit;

   // tallies
   logic [HIT_W-1:0] request_total, success_total, failure_total;
   logic [HIT_W-1:0] class_counts [4];
   logic [SUM_W-1:0] response_sum, byte_total;
   logic [31:0]      response_min, response_max;
   logic [HIT_W-1:0] server_hits [SERVERS];
   logic [SUM_W-1:0] server_sums [SERVERS];
   logic [HIT_W-1:0] endpoint_hits [ENDPOINTS];
   logic [SUM_W-1:0] endpoint_sums [ENDPOINTS];
   logic [HIT_W-1:0] interval_hits [INTERVALS];

   function automatic void queue_record(logic [3:0] kind, logic [15:0] id,
                                        logic [HIT_W-1:0] hits, logic [SUM_W-1:0] amt);
      stat_record_type r;
      r.kind = kind;
      r.id = id;
      r.hits = hits;
      r.amount = amt;
      r.last = 1'b0;
      report_queue = {report_queue, r};
   endfunction

   // Pick entries in rank order: count descending, then index ascending.
   function automatic void queue_top(logic [3:0] kind, input logic [HIT_W-1:0] hits [],
                                     input logic [SUM_W-1:0] vals [], int lim, bit average);
      bit have_prev;
      bit found;
      logic [HIT_W-1:0] pc, bc;
      int pi, bi;
      have_prev = 0;
      pc = '0;
      pi = 0;
      for (int k = 0; k < lim; k++) begin
         found = 0;
         bc = '0;
         bi = 0;
         for (int i = 0; i < hits.size(); i++) begin
            if (hits[i] == 0) continue;
            // skip anything not ranked strictly after the previous pick
            if (have_prev && !(pc > hits[i] || (pc == hits[i] && pi < i))) continue;
            if (!found || hits[i] > bc) begin
               found = 1;
               bc = hits[i];
               bi = i;
            end
         end
         if (!found) return;
         queue_record(kind, bi[15:0], bc,
                      average ? vals[bi] / {{(SUM_W-HIT_W){1'b0}}, bc} : vals[bi]);
         have_prev = 1;
         pc = bc;
         pi = bi;
      end
   endfunction

   function automatic void predict_report();
      bit any;
      int lim;
      logic [HIT_W-1:0] busiest_hits;
      int busiest_id;
      stat_record_type r;
      any = (request_total != 0);
      lim = (top_count > MAX_TOP) ? MAX_TOP : top_count;
      queue_record(KIND_TOTAL, '0, request_total, '0);
      queue_record(KIND_OK, '0, success_total, '0);
      queue_record(KIND_FAILED, '0, failure_total, '0);
      queue_record(KIND_AVERAGE, '0, '0,
                   any ? response_sum / {{(SUM_W-HIT_W){1'b0}}, request_total} : '0);
      queue_record(KIND_MIN, '0, '0, any ? {32'd0, response_min} : '0);
      queue_record(KIND_MAX, '0, '0, any ? {32'd0, response_max} : '0);
      queue_record(KIND_BYTES, '0, '0, byte_total);
      queue_record(KIND_CLASS2, '0, class_counts[0], '0);
      queue_record(KIND_CLASS3, '0, class_counts[1], '0);
      queue_record(KIND_CLASS4, '0, class_counts[2], '0);
      queue_record(KIND_CLASS5, '0, class_counts[3], '0);
      // lowest index wins a tie
      busiest_hits = '0;
      busiest_id = 0;
      for (int i = 0; i < INTERVALS; i++) begin
         if (interval_hits[i] > busiest_hits) begin
            busiest_hits = interval_hits[i];
            busiest_id = i;
         end
      end
      queue_record(KIND_BUSIEST, busiest_id[15:0], busiest_hits, '0);
      queue_top(KIND_SERVER, server_hits, server_sums, lim, 1);
      queue_top(KIND_ENDPOINT, endpoint_hits, endpoint_sums, lim, 0);
      r = report_queue.pop_back();
      r.last = 1'b1;
      report_queue = {report_queue, r};
   endfunction

   function automatic void tally_request();
      logic [31:0] interval;
      interval = req_timestamp / 32'd60;
      request_total++;
      if (req_status_code < STATUS_400) success_total++;
      else failure_total++;
      if (req_status_code >= STATUS_200 && req_status_code < STATUS_600)
         class_counts[req_status_code / 100 - 2]++;
      response_sum += req_response_time;
      if (req_response_time < response_min) response_min = req_response_time;
      if (req_response_time > response_max) response_max = req_response_time;
      byte_total += req_byte_count;
      if (req_server_id < server_limit && req_server_id < SERVERS) begin
         server_hits[req_server_id]++;
         server_sums[req_server_id] += req_response_time;
      end
      if (req_endpoint_id < ENDPOINTS) begin
         endpoint_hits[req_endpoint_id]++;
         endpoint_sums[req_endpoint_id] += req_byte_count;
      end
      if (interval < INTERVALS) interval_hits[interval]++;
   endfunction

   assign outstanding = report_queue.size();

   always @(posedge clock) begin
      stat_record_type want;
      if (reset) begin
         top_count = TOP_COUNT_RESET;
         server_limit = SERVER_LIMIT_RESET;
         request_total = '0;
         success_total = '0;
         failure_total = '0;
         for (int i = 0; i < 4; i++) class_counts[i] = '0;
         response_sum = '0;
         byte_total = '0;
         response_min = '1;
         response_max = '0;
         for (int i = 0; i < SERVERS; i++) begin
            server_hits[i] = '0;
            server_sums[i] = '0;
         end
         for (int i = 0; i < ENDPOINTS; i++) begin
            endpoint_hits[i] = '0;
            endpoint_sums[i] = '0;
         end
         for (int i = 0; i < INTERVALS; i++) interval_hits[i] = '0;
         report_queue.delete();
         failures = 0;
      end else begin
         // compare the record on the strobe with the oldest prediction
         if (rsp_valid) begin
            if (report_queue.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected report record kind=%0d id=%0d hits=%0d amount=%0d",
                           rsp_record_kind, rsp_entry_id, rsp_hit_count, rsp_amount);
            end else begin
               want = report_queue.pop_front();
               if (rsp_record_kind !== want.kind || rsp_entry_id !== want.id ||
                   rsp_hit_count !== want.hits || rsp_amount !== want.amount ||
                   rsp_last !== want.last) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("record mismatch: expected kind=%0d id=%0d hits=%0d %s",
                              want.kind, want.id, want.hits, "");
                     $display("   expected amount=%0d last=%0d", want.amount, want.last);
                     $display("   got kind=%0d id=%0d hits=%0d amount=%0d last=%0d",
                              rsp_record_kind, rsp_entry_id, rsp_hit_count,
                              rsp_amount, rsp_last);
                  end
               end
            end
         end
         // register writes
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CSR_TOP_COUNT) top_count = pwdata[4:0];
            else server_limit = pwdata[6:0];
         end
         // accepted request
         if (start && !busy) begin
            if (req_operation) predict_report();
            else tally_request();
         end
      end
   end

endmodule

// ===== tb/tb_request_log_statistics_topk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_request_log_statistics_topk
// Drives tally and report requests with bursty timing through several
// register settings; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_request_log_statistics_topk;
   import rlst_pkg::*;

   localparam int STALL_LIMIT = 40000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_operation;
   logic [31:0]       req_timestamp;
   logic [7:0]        req_server_id;
   logic [15:0]       req_endpoint_id;
   logic [9:0]        req_status_code;
   logic [31:0]       req_response_time;
   logic [31:0]       req_byte_count;
   logic              rsp_valid;
   logic [3:0]        rsp_record_kind;
   logic [15:0]       rsp_entry_id;
   logic [HIT_W-1:0]  rsp_hit_count;
   logic [SUM_W-1:0]  rsp_amount;
   logic              rsp_last;
   logic              psel, penable, pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;
   int                failures;
   int                outstanding;
   int                stall_cycles;

   request_log_statistics_topk u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_timestamp(req_timestamp),
      .req_server_id(req_server_id), .req_endpoint_id(req_endpoint_id),
      .req_status_code(req_status_code), .req_response_time(req_response_time),
      .req_byte_count(req_byte_count), .rsp_valid(rsp_valid),
      .rsp_record_kind(rsp_record_kind), .rsp_entry_id(rsp_entry_id),
      .rsp_hit_count(rsp_hit_count), .rsp_amount(rsp_amount), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   request_log_statistics_topk_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_timestamp(req_timestamp),
      .req_server_id(req_server_id), .req_endpoint_id(req_endpoint_id),
      .req_status_code(req_status_code), .req_response_time(req_response_time),
      .req_byte_count(req_byte_count), .rsp_valid(rsp_valid),
      .rsp_record_kind(rsp_record_kind), .rsp_entry_id(rsp_entry_id),
      .rsp_hit_count(rsp_hit_count), .rsp_amount(rsp_amount), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .failures(failures), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Count cycles in which no request and no record moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_request_log_statistics_topk failed");
            $finish;
         end
      end
   end

   // Present one request and hold it until accepted; leaves start high.
   task automatic issue(logic op, logic [31:0] ts, logic [7:0] srv, logic [15:0] ep,
                        logic [9:0] status, logic [31:0] rt, logic [31:0] nbytes);
      req_operation = op;
      req_timestamp = ts;
      req_server_id = srv;
      req_endpoint_id = ep;
      req_status_code = status;
      req_response_time = rt;
      req_byte_count = nbytes;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic tally(logic [31:0] ts, logic [7:0] srv, logic [15:0] ep,
                        logic [9:0] status, logic [31:0] rt, logic [31:0] nbytes);
      issue(1'b0, ts, srv, ep, status, rt, nbytes);
   endtask

   task automatic report();
      issue(1'b1, $urandom, 8'($urandom), 16'($urandom), 10'($urandom), $urandom,
            $urandom);
   endtask

   // Drop start and hold until the block is idle and every record is in.
   task automatic drain();
      start = 1'b0;
      @(negedge clock);
      while (busy || outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic index, logic [31:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {index, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // Random tally with hot servers and endpoints so ranks tie and shift.
   task automatic random_tally();
      logic [31:0] ts;
      logic [7:0]  srv;
      logic [15:0] ep;
      logic [9:0]  status;
      logic [31:0] rt;
      ts  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 61439);
      if ($urandom_range(0, 3) == 0) ts = $urandom_range(0, 599);
      srv = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
      ep  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
      status = 10'($urandom_range(0, 999));
      if ($urandom_range(0, 1) == 0) status = 10'($urandom_range(200, 599));
      rt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
      tally(ts, srv, ep, status, rt, $urandom);
   endtask

   task automatic random_phase(int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && sent < count; b++) begin
            if ($urandom_range(0, 9) == 0) report();
            else random_tally();
            sent++;
         end
         // idle gap between bursts, sometimes none
         if ($urandom_range(0, 3) != 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      report();
      drain();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = 1'b0;
      req_timestamp = '0;
      req_server_id = '0;
      req_endpoint_id = '0;
      req_status_code = '0;
      req_response_time = '0;
      req_byte_count = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // report on empty tables: zero average, min and max, no lists
      report();
      drain();

      // status borders, field extremes and out-of-range indices
      tally(32'd0, 8'd0, 16'd0, 10'd0, 32'd0, 32'd0);
      tally(32'd61439, 8'd63, 16'd255, 10'd199, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      tally(32'd61440, 8'd64, 16'd256, 10'd200, 32'h0001_8000, 32'd100);
      tally(32'hFFFF_FFFF, 8'd255, 16'hFFFF, 10'd399, 32'h0000_0001, 32'd7);
      tally(32'd59, 8'd63, 16'd255, 10'd400, 32'h0002_0000, 32'd1);
      tally(32'd60, 8'd1, 16'd3, 10'd599, 32'h0003_0000, 32'd5);
      tally(32'd60, 8'd1, 16'd3, 10'd600, 32'h0000_4000, 32'd9);
      tally(32'd119, 8'd0, 16'd0, 10'd999, 32'h7FFF_FFFF, 32'h8000_0000);
      tally(32'd61439, 8'd2, 16'd4, 10'd300, 32'h0000_0003, 32'd2);
      tally(32'd61439, 8'd2, 16'd4, 10'd500, 32'h0000_0005, 32'd2);
      report();
      drain();

      // no lists at all, nothing tallied per server
      write_csr(CSR_TOP_COUNT, 32'd0);
      write_csr(CSR_SERVER_LIMIT, 32'd0);
      tally(32'd30, 8'd0, 16'd1, 10'd204, 32'h0000_1000, 32'd3);
      report();
      drain();

      write_csr(CSR_TOP_COUNT, 32'd16);
      write_csr(CSR_SERVER_LIMIT, 32'd64);
      random_phase(70);

      // above the list maximum, limit beyond the table
      write_csr(CSR_TOP_COUNT, 32'd31);
      write_csr(CSR_SERVER_LIMIT, 32'd127);
      random_phase(70);

      write_csr(CSR_TOP_COUNT, 32'd1);
      write_csr(CSR_SERVER_LIMIT, 32'd5);
      random_phase(70);

      write_csr(CSR_TOP_COUNT, 32'd5);
      write_csr(CSR_SERVER_LIMIT, 32'd64);
      random_phase(90);

      start = 1'b0;
      while (busy || outstanding != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("tb_request_log_statistics_topk passed");
      end else begin
         $display("tb_request_log_statistics_topk failed");
      end
      $finish;
   end

endmodule

// ===== request_log_statistics_topk.f =====
+incdir+rtl/core
rtl/core/rlst_pkg.sv
rtl/core/rlst_ram.sv
rtl/core/rlst_div.sv
rtl/core/request_log_statistics_topk.sv
tb/request_log_statistics_topk_checker.sv
tb/tb_request_log_statistics_topk.sv
